// ===== sv/shm_pkg.sv =====
// ----------------------------------------------------------------------------
// shm_pkg
// Types and constants that the keyed string hash modules share.
// ----------------------------------------------------------------------------
package shm_pkg;

	// width of the post-fold arithmetic (product, sum and remainder)
	localparam int WORD_W    = 64;
	// width of the configuration registers and of the result word
	localparam int REG_W     = 63;
	localparam int CHAR_W    = 8;
	// iteration counter: covers up to WORD_W steps
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MULT_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_P = 2'd2;

	localparam logic [REG_W-1:0] MULT_A_RST    = 63'd1;
	localparam logic [REG_W-1:0] OFFSET_B_RST  = 63'd0;
	localparam logic [REG_W-1:0] MODULUS_P_RST = 63'd17;

	typedef logic [REG_W-1:0] reg_word_t;

	// control from the top level to the running hash
	typedef struct packed {
		logic fold;
		logic clear;
	} fold_ctl_t;

	// status of the multiply and reduce unit
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

// ===== sv/shm_fold.sv =====
// ----------------------------------------------------------------------------
// shm_fold
// Running sdbm hash register with its combinational character fold.
// ----------------------------------------------------------------------------
module shm_fold #(
	parameter int HASH_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shm_pkg::fold_ctl_t            ctl,
	input  logic [shm_pkg::CHAR_W-1:0]    key_char,
	output logic [HASH_WIDTH-1:0]         hash_q,
	output logic [HASH_WIDTH-1:0]         fold_sum
);

	logic [HASH_WIDTH-1:0] char_ext;

	assign char_ext = {{(HASH_WIDTH-shm_pkg::CHAR_W){1'b0}}, key_char};

	// h*65599 + c, wrapping at the hash width
	assign fold_sum = char_ext + (hash_q << 6) + (hash_q << 16) - hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (ctl.clear) begin
			hash_q <= '0;
		end else if (ctl.fold) begin
			hash_q <= fold_sum;
		end
	end

endmodule

// ===== sv/shm_mulmod.sv =====
// ----------------------------------------------------------------------------
// shm_mulmod
// Computes (a*h + b) mod 2^64, then mod p, on one shared 64-bit adder:
// shift-and-add multiply, one add, restoring remainder.
// ----------------------------------------------------------------------------
module shm_mulmod #(
	parameter int HASH_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       take,
	input  logic [HASH_WIDTH-1:0]      hash_in,
	input  shm_pkg::reg_word_t         mult_a,
	input  shm_pkg::reg_word_t         offset_b,
	input  shm_pkg::reg_word_t         modulus_p,
	output shm_pkg::mm_stat_t          stat,
	output shm_pkg::reg_word_t         result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam int W = shm_pkg::WORD_W;

	logic [2:0]                  state_q;
	logic [shm_pkg::CNT_W-1:0]   cnt_q;
	logic [W-1:0]                acc_q;
	logic [W-1:0]                mcand_q;
	logic [HASH_WIDTH-1:0]       mplier_q;
	logic [W-1:0]                rem_q;

	logic [W-1:0]                rem_shift;
	logic [W-1:0]                op_x;
	logic [W-1:0]                op_y;
	logic                        op_sub;
	logic [W:0]                  sum;

	assign rem_shift = {rem_q[W-2:0], acc_q[W-1]};

	// shared adder; carry out on subtract means no borrow (x >= y)
	always_comb begin
		op_x   = acc_q;
		op_y   = '0;
		op_sub = 1'b0;
		unique case (state_q)
			ST_MUL: begin
				op_y = mcand_q;
			end
			ST_ADD: begin
				op_y = {1'b0, offset_b};
			end
			ST_DIV: begin
				op_x   = rem_shift;
				op_y   = {1'b0, modulus_p};
				op_sub = 1'b1;
			end
			default: begin
				op_y = '0;
			end
		endcase
	end

	assign sum = {1'b0, op_x} + {1'b0, (op_sub ? ~op_y : op_y)} + {{W{1'b0}}, op_sub};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						cnt_q   <= shm_pkg::CNT_W'(HASH_WIDTH - 1);
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_ADD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_ADD: begin
					state_q <= ST_DIV;
					cnt_q   <= shm_pkg::CNT_W'(W - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					acc_q    <= '0;
					mcand_q  <= {1'b0, mult_a};
					mplier_q <= hash_in;
				end
			end
			ST_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= sum[W-1:0];
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			ST_ADD: begin
				acc_q <= sum[W-1:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= sum[W] ? sum[W-1:0] : rem_shift;
				acc_q <= acc_q << 1;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	// no reduction exists for a zero modulus: report zero
	assign result = (modulus_p == '0) ? '0 : rem_q[shm_pkg::REG_W-1:0];

endmodule

// ===== sv/string_hash_mod_prime.sv =====
// ----------------------------------------------------------------------------
// string_hash_mod_prime
// Keyed string hash: sdbm fold of key characters, then (a*h + b) mod p.
// ----------------------------------------------------------------------------
// Key characters come in one word per cycle and fold into a running sdbm
// hash (h = c + h*65599, wrapping at HASH_WIDTH bits) with no stall. A zero
// character ends the key without being folded; a nonzero character with
// last_char set is folded and then ends the key. At key end the running
// hash clears and the keyed reduction (mult_a*h + offset_b, wrapping at 64
// bits, then mod modulus_p) runs on one shared 64-bit adder: shift-and-add
// multiply, one add for the offset, then restoring remainder. The input
// stalls during that time, until the result is taken into the output
// register; the result then waits there while new characters stream in.
// A modulus of zero yields hash_value 0. The configuration registers
// (index 0 mult_a, 1 offset_b, 2 modulus_p) must be written only while no
// key end is in flight; the block does not enforce this. cfg_ready is
// always high and a write to index 3 is dropped.
// ----------------------------------------------------------------------------
module string_hash_mod_prime #(
	parameter int HASH_WIDTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// character channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [shm_pkg::CHAR_W-1:0]        key_char,
	input  logic                              last_char,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [shm_pkg::REG_W-1:0]         hash_value,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [shm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [shm_pkg::REG_W-1:0]         cfg_data
);

	shm_pkg::reg_word_t      mult_a_q;
	shm_pkg::reg_word_t      offset_b_q;
	shm_pkg::reg_word_t      modulus_p_q;

	logic                    in_accept;
	logic                    char_nz;
	logic                    key_end;
	shm_pkg::fold_ctl_t      fold_ctl;
	logic [HASH_WIDTH-1:0]   hash_q;
	logic [HASH_WIDTH-1:0]   fold_sum;
	logic [HASH_WIDTH-1:0]   final_hash;

	shm_pkg::mm_stat_t       mm_stat;
	shm_pkg::reg_word_t      mm_result;
	logic                    take;

	logic                    out_valid_q;
	shm_pkg::reg_word_t      hash_value_q;

	// Configuration: always ready; the user must write only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_a_q    <= shm_pkg::MULT_A_RST;
			offset_b_q  <= shm_pkg::OFFSET_B_RST;
			modulus_p_q <= shm_pkg::MODULUS_P_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				shm_pkg::CFG_MULT_A:    mult_a_q    <= cfg_data;
				shm_pkg::CFG_OFFSET_B:  offset_b_q  <= cfg_data;
				shm_pkg::CFG_MODULUS_P: modulus_p_q <= cfg_data;
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	// Hold the character channel while the reduction unit owns a key.
	assign in_stall  = mm_stat.busy;
	assign in_accept = in_valid && !in_stall;
	assign char_nz   = (key_char != '0);
	assign key_end   = in_accept && (!char_nz || last_char);

	assign fold_ctl.fold  = in_accept && char_nz;
	assign fold_ctl.clear = key_end;

	shm_fold #(
		.HASH_WIDTH (HASH_WIDTH)
	) u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (fold_ctl),
		.key_char (key_char),
		.hash_q   (hash_q),
		.fold_sum (fold_sum)
	);

	// A last nonzero character is folded on the way into the reduction.
	assign final_hash = char_nz ? fold_sum : hash_q;

	shm_mulmod #(
		.HASH_WIDTH (HASH_WIDTH)
	) u_mulmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (key_end),
		.take      (take),
		.hash_in   (final_hash),
		.mult_a    (mult_a_q),
		.offset_b  (offset_b_q),
		.modulus_p (modulus_p_q),
		.stat      (mm_stat),
		.result    (mm_result)
	);

	// Output register: move the finished word out of the unit as soon as the
	// register is empty or is being drained this cycle.
	assign take = mm_stat.done && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hash_value_q <= mm_result;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;

	// A key end must find the reduction unit free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		key_end |-> !mm_stat.busy)
		else $error("key end while reduction unit busy");

	// A new result word comes only from a finished reduction.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(mm_stat.done))
		else $error("result word without finished reduction");

	// The reduced word lies below the modulus.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (modulus_p_q != '0)) |-> (hash_value_q < modulus_p_q))
		else $error("result word not below modulus");

	// The running hash is clear after a key end.
	a_hash_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		key_end |=> (hash_q == '0))
		else $error("running hash not cleared at key end");

endmodule

// ===== sim/tb_string_hash_mod_prime.sv =====
// ----------------------------------------------------------------------------
// tb_string_hash_mod_prime
// Self-checking regression for the keyed sdbm string hash.
// ----------------------------------------------------------------------------
// Feeds key characters through the valid/stall channel and predicts every
// keyed hash word in a small scoreboard. The scoreboard models the 64-bit
// sdbm fold and the (a*h + b) mod p reduction. A short directed part covers
// the corner cases. It is followed by phases of random keys, each phase
// under a new register setting. Both sides idle at random, one phase runs
// with no idling, and one phase holds the result side off long enough that
// the block backs up.
// ----------------------------------------------------------------------------
module tb_string_hash_mod_prime;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int ITEM_TARGET   = 1050;
	localparam int PHASE_ITEMS   = 130;
	localparam int HOLD_CYCLES   = 400;
	// wait for the reduction unit to go idle; allow a wide margin
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT   = 4000;
	localparam int IDLE_PCT      = 27;

	localparam logic [shm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam shm_pkg::reg_word_t REG_MAX   = '1;
	// largest prime below 2**63
	localparam shm_pkg::reg_word_t BIG_PRIME = 63'h7FFF_FFFF_FFFF_FFE7;

	// keyed hash predictor plus the queue of hash words still to come
	class hash_scoreboard;
		shm_pkg::reg_word_t mult_a;
		shm_pkg::reg_word_t offset_b;
		shm_pkg::reg_word_t modulus_p;
		logic [63:0]        fold_state;
		shm_pkg::reg_word_t expected_q[$];
		int                 errors;

		function new();
			mult_a     = shm_pkg::MULT_A_RST;
			offset_b   = shm_pkg::OFFSET_B_RST;
			modulus_p  = shm_pkg::MODULUS_P_RST;
			fold_state = '0;
			errors     = 0;
		endfunction

		function void note_config(logic [shm_pkg::CFG_IDX_W-1:0] idx,
		                          shm_pkg::reg_word_t data);
			case (idx)
			shm_pkg::CFG_MULT_A:    mult_a    = data;
			shm_pkg::CFG_OFFSET_B:  offset_b  = data;
			shm_pkg::CFG_MODULUS_P: modulus_p = data;
			default:                ;
			endcase
		endfunction

		// fold a nonzero character; a zero or a flagged last character ends the key
		function void note_char(logic [shm_pkg::CHAR_W-1:0] c, logic last);
			logic [63:0] keyed;
			if (c != '0) begin
				fold_state = 64'(c) + (fold_state << 6) + (fold_state << 16) - fold_state;
				if (!last)
					return;
			end
			keyed = 64'(mult_a) * fold_state + 64'(offset_b);
			expected_q.push_back((modulus_p == '0) ? '0 :
				shm_pkg::reg_word_t'(keyed % 64'(modulus_p)));
			fold_state = '0;
		endfunction

		function void check_word(shm_pkg::reg_word_t got);
			shm_pkg::reg_word_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected hash_value %0h, nothing expected", $time, got);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: hash_value mismatch, expected %0h, actual %0h",
					$time, want, got);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	logic [shm_pkg::CHAR_W-1:0]    key_char  = '0;
	logic                          last_char = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	shm_pkg::reg_word_t            hash_value;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [shm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	shm_pkg::reg_word_t            cfg_data  = '0;

	hash_scoreboard sb = new();
	int             chars_sent  = 0;
	int             quiet_count = 0;
	// calm: no idling on either side; hold_req: ask the receiver for a long hold-off
	bit             calm        = 1'b0;
	bit             hold_req    = 1'b0;

	string_hash_mod_prime u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key_char   (key_char),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Monitor: sample all handshakes at the edge. Check the result word
	// before noting the input, since a key end taken at this edge cannot
	// show up at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_word(hash_value);
			if (in_valid && !in_stall)
				sb.note_char(key_char, last_char);
			if (cfg_valid && cfg_ready)
				sb.note_config(cfg_index, cfg_data);
		end
	end

	// Watchdog: end the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((out_valid && !out_stall) || (in_valid && !in_stall) ||
			    (cfg_valid && cfg_ready))
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_count);
				$display("string_hash_mod_prime regression: fail");
				$finish;
			end
		end
	end

	// Receiver: stall at random, except in the calm phase. On request, hold
	// off for a long stretch so that the block fills up and stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic shm_pkg::reg_word_t rand_word();
		return shm_pkg::reg_word_t'({$urandom(), $urandom()});
	endfunction

	// Pick a register value: mostly extremes and small values, some random.
	function automatic shm_pkg::reg_word_t pick_value();
		int sel;
		sel = $urandom_range(6);
		case (sel)
		0:       return '0;
		1:       return shm_pkg::reg_word_t'(1);
		2:       return REG_MAX;
		3:       return BIG_PRIME;
		4:       return shm_pkg::reg_word_t'($urandom_range(2, 1000));
		default: return rand_word();
		endcase
	endfunction

	// Offer one character, hold it until taken, then maybe idle a little.
	// Leave in_valid high when not idling so the next word follows at once.
	task automatic send_char(input logic [shm_pkg::CHAR_W-1:0] c, input logic last);
		in_valid  <= 1'b1;
		key_char  <= c;
		last_char <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		chars_sent++;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Drop valid, wait for every expected word, then let the reduction unit go idle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hold cfg_valid across back-to-back writes; the caller lowers it.
	task automatic write_reg(input logic [shm_pkg::CFG_IDX_W-1:0] idx,
	                         input shm_pkg::reg_word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_config(input shm_pkg::reg_word_t a, input shm_pkg::reg_word_t b,
	                           input shm_pkg::reg_word_t p, input bit poke_unused);
		write_reg(shm_pkg::CFG_MULT_A, a);
		write_reg(shm_pkg::CFG_OFFSET_B, b);
		write_reg(shm_pkg::CFG_MODULUS_P, p);
		if (poke_unused)
			write_reg(CFG_UNUSED, rand_word());
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed keys with random content; the rest is noise.
	task automatic send_random_key();
		int kind;
		int len;
		kind = $urandom_range(99);
		if (kind < 15) begin
			send_char(shm_pkg::CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
			return;
		end
		len = (kind < 22) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		for (int i = 0; i < len; i++)
			send_char(shm_pkg::CHAR_W'($urandom_range(1, 255)),
				(i == len - 1) && (kind % 2 == 0));
		// odd kinds end with a zero terminator, flagged last or not
		if (kind % 2 == 1)
			send_char('0, 1'($urandom_range(1)));
	endtask

	initial begin
		int phase_end;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: empty key, zero with the last flag, extreme characters
		send_char(8'h00, 1'b0);
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(8'h01, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'h7F, 1'b0);
		send_char(8'h00, 1'b0);

		// largest multiplier and offset with the big prime: wraps before the modulo
		settle();
		load_config(REG_MAX, REG_MAX, BIG_PRIME, 1'b1);
		repeat (5) send_char(8'hFF, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b0);

		// modulus zero: word is zero, fold state still clears
		settle();
		load_config(REG_MAX, REG_MAX, '0, 1'b0);
		send_char(8'h55, 1'b1);
		send_char(8'h00, 1'b0);

		// modulus one, then two, with a zero carrying the last flag
		settle();
		load_config(shm_pkg::reg_word_t'(1), '0, shm_pkg::reg_word_t'(1), 1'b0);
		send_char(8'hAA, 1'b1);
		settle();
		load_config(rand_word(), rand_word(), shm_pkg::reg_word_t'(2), 1'b0);
		send_char(8'h3C, 1'b0);
		send_char(8'h00, 1'b1);

		// random phases, each under a fresh setting
		for (int phase = 0; chars_sent < ITEM_TARGET; phase++) begin
			settle();
			load_config(pick_value(), pick_value(), pick_value(), phase == 1);
			calm = (phase == 2);
			if (phase == 4)
				hold_req = 1'b1;
			phase_end = chars_sent + PHASE_ITEMS;
			while (chars_sent < phase_end)
				send_random_key();
		end
		calm = 1'b0;

		settle();
		if (sb.pending() != 0)
			$display("%0t: %0d hash words never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("string_hash_mod_prime regression: pass");
		else
			$display("string_hash_mod_prime regression: fail");
		$finish;
	end

endmodule
